// ----- src/angle_factor_rotate_residual_macros.svh -----
// Assertion macros for the checker file afr_chk.sv.
// Needs a clk and an active-low rst_n in the scope of use.
`ifndef ANGLE_FACTOR_ROTATE_RESIDUAL_MACROS_SVH
`define ANGLE_FACTOR_ROTATE_RESIDUAL_MACROS_SVH

// same-cycle implication
`define AFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/afr_pkg.sv -----
// Shared types, constants and helpers of the angle factor datapath.
// No dependencies; all other files but the macro header use this package.
`timescale 1ns / 1ps

package afr_pkg;

  typedef logic [1:0]         edge_idx_t;
  typedef logic signed [16:0] angle_t;
  typedef logic signed [31:0] vec_t;
  typedef logic signed [31:0] q30_t;
  typedef logic [31:0]        udata_t;

  typedef struct packed {
    edge_idx_t edge_index;
    vec_t      est_x;
    vec_t      est_y;
    vec_t      est_z;
    vec_t      nb_x;
    vec_t      nb_y;
    vec_t      nb_z;
  } side_t;

  typedef struct packed {
    logic        busy;
    logic [32:0] inv;
  } cfg_stat_t;

  localparam int SIDE_W  = $bits(side_t);
  localparam int TRIG_ST = 15;
  localparam int ROT_ST  = 7;
  localparam int NST     = TRIG_ST + ROT_ST;

  localparam int FULL_TURN    = 46080;
  localparam int HALF_TURN    = 23040;
  localparam int QUARTER_TURN = 11520;
  localparam int EIGHTH_TURN  = 5760;

  localparam logic [47:0] RAD_K  = 48'd9595049034;
  localparam logic [30:0] H_ONE  = 31'h4000_0000;
  localparam q30_t        Q30_P1 = 32'sh4000_0000;
  localparam q30_t        Q30_MH = -32'sh2000_0000;
  localparam q30_t        SIN60  = 32'sd929887697;

  localparam int unsigned SIN_DIV [4] = '{72, 42, 20, 6};
  localparam int unsigned COS_DIV [5] = '{90, 56, 30, 12, 2};

  localparam logic [1:0]  ADDR_SIGMA  = 2'd0;
  localparam logic [15:0] SIGMA_RST   = 16'd256;
  localparam logic [32:0] INV_RST     = 33'd65536;
  localparam int          DIV_STEPS   = 34;

  localparam edge_idx_t EDGE_120 = 2'd1;
  localparam edge_idx_t EDGE_240 = 2'd2;

  // round half away from zero, drop 30 fraction bits
  function automatic logic signed [63:0] round_q30(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? (~v + 64'd1) : v;
    r   = (mag + (64'd1 << 29)) >> 30;
    return v[63] ? $signed(~r + 64'd1) : $signed(r);
  endfunction

endpackage

// ----- src/afr_if.sv -----
// Valid/ready channel interfaces for input words and result words.
// Depends on afr_pkg.
`timescale 1ns / 1ps

interface afr_in_if;
  import afr_pkg::*;
  logic      valid;
  logic      ready;
  edge_idx_t edge_index;
  angle_t    joint_angle;
  vec_t      est_x;
  vec_t      est_y;
  vec_t      est_z;
  vec_t      nb_x;
  vec_t      nb_y;
  vec_t      nb_z;

  modport source (output valid, edge_index, joint_angle, est_x, est_y, est_z,
                  nb_x, nb_y, nb_z, input ready);
  modport sink   (input valid, edge_index, joint_angle, est_x, est_y, est_z,
                  nb_x, nb_y, nb_z, output ready);
endinterface

interface afr_out_if;
  import afr_pkg::*;
  logic   valid;
  logic   ready;
  vec_t   eta_x;
  vec_t   eta_y;
  vec_t   eta_z;
  udata_t info_diag;

  modport source (output valid, eta_x, eta_y, eta_z, info_diag, input ready);
  modport sink   (input valid, eta_x, eta_y, eta_z, info_diag, output ready);
endinterface

// ----- src/angle_factor_rotate_residual.sv -----
// Pipeline of 22 register stages; a result word is valid once its input word has passed all of them.
// Throughput: one word per cycle while out_if.ready is high and no divide runs; per-stage enables let bubbles close up.
// A sigma write starts a 34-step serial divide; input is held off while it runs.
// Reset (rst_n low, synchronous): pipeline valids cleared, sigma = 1.0.
// Depends on afr_pkg, afr_if, afr_delay, afr_trig, afr_cfg, afr_rot.
`timescale 1ns / 1ps

module angle_factor_rotate_residual (
  input  logic        clk,
  input  logic        rst_n,
  afr_in_if.sink      in_if,
  afr_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import afr_pkg::*;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;
  logic           in_acc;
  cfg_stat_t      stat;
  side_t          side_in;
  side_t          side_d;
  q30_t           cos_w;
  q30_t           sin_w;

  // stage loads when empty or when the next stage moves
  assign en[NST-1] = ~v_r[NST-1] | out_if.ready;
  for (genvar i = 0; i < NST - 1; i++) begin : g_en
    assign en[i] = ~v_r[i] | en[i+1];
  end

  assign in_if.ready = en[0] & ~stat.busy;
  assign in_acc      = in_if.valid & in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) v_r[i] <= (i == 0) ? in_acc : v_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign side_in = '{edge_index: in_if.edge_index,
                     est_x: in_if.est_x, est_y: in_if.est_y, est_z: in_if.est_z,
                     nb_x: in_if.nb_x, nb_y: in_if.nb_y, nb_z: in_if.nb_z};

  afr_trig u_trig (
    .clk   (clk),
    .en    (en[TRIG_ST-1:0]),
    .angle (in_if.joint_angle),
    .cos_o (cos_w),
    .sin_o (sin_w)
  );

  afr_delay #(
    .WIDTH (SIDE_W),
    .DEPTH (TRIG_ST)
  ) u_side (
    .clk (clk),
    .en  (en[TRIG_ST-1:0]),
    .d   (side_in),
    .q   (side_d)
  );

  afr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .stat    (stat)
  );

  afr_rot u_rot (
    .clk       (clk),
    .en        (en[NST-1:TRIG_ST]),
    .cos_i     (cos_w),
    .sin_i     (sin_w),
    .side      (side_d),
    .inv       (stat.inv),
    .eta_x     (out_if.eta_x),
    .eta_y     (out_if.eta_y),
    .eta_z     (out_if.eta_z),
    .info_diag (out_if.info_diag)
  );

  assign out_if.valid = v_r[NST-1];
endmodule

// ----- src/afr_delay.sv -----
// Enable-driven delay line keeping side data aligned with the trig pipe.
// Depends on afr_pkg.
`timescale 1ns / 1ps

module afr_delay #(
  parameter int WIDTH = afr_pkg::SIDE_W,
  parameter int DEPTH = afr_pkg::TRIG_ST
) (
  input  logic             clk,
  input  logic [DEPTH-1:0] en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);
  logic [WIDTH-1:0] stage_r [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (en[i]) begin
        stage_r[i] <= (i == 0) ? d : stage_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign q = stage_r[DEPTH-1];
endmodule

// ----- src/afr_trig.sv -----
// Cos/sin pipeline: phase wrap, octant fold, truncating Horner series.
// Depends on afr_pkg. One stage per en bit.
`timescale 1ns / 1ps

module afr_trig (
  input  logic                          clk,
  input  logic [afr_pkg::TRIG_ST-1:0]   en,
  input  afr_pkg::angle_t               angle,
  output afr_pkg::q30_t                 cos_o,
  output afr_pkg::q30_t                 sin_o
);
  import afr_pkg::*;

  typedef struct packed {
    logic [1:0]  quad;
    logic        swap;
    logic [29:0] x;
    logic [29:0] x2;
  } trig_side_t;

  logic signed [17:0] d;
  logic signed [17:0] t_full;
  logic [15:0]        t_r;
  logic [1:0]         quad;
  logic [13:0]        rem;
  logic               swap;
  logic [12:0]        u1_r;
  logic [47:0]        x_prod;
  logic [59:0]        x2_prod;
  trig_side_t         side_r [1:TRIG_ST-2];
  logic [30:0]        hc_in [6];
  logic [30:0]        hs_in [5];
  logic [30:0]        hsp_r;
  logic [30:0]        hsq_r;
  logic [60:0]        s_prod;
  logic [30:0]        c0;
  logic [30:0]        s0;
  q30_t               cv;
  q30_t               sv;
  q30_t               cos_r;
  q30_t               sin_r;

  // stage 0: phase = (180 deg - angle) mod 360 deg
  always_comb begin
    d = 18'(HALF_TURN) - 18'(angle);
    if (d < 0) begin
      t_full = d + 18'(FULL_TURN);
    end else if (d >= 18'(FULL_TURN)) begin
      t_full = d - 18'(FULL_TURN);
    end else begin
      t_full = d;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) t_r <= t_full[15:0];
  end

  // stage 1: quadrant and octant fold
  always_comb begin
    if (t_r >= 16'(3 * QUARTER_TURN)) begin
      quad = 2'd3;
      rem  = 14'(t_r - 16'(3 * QUARTER_TURN));
    end else if (t_r >= 16'(HALF_TURN)) begin
      quad = 2'd2;
      rem  = 14'(t_r - 16'(HALF_TURN));
    end else if (t_r >= 16'(QUARTER_TURN)) begin
      quad = 2'd1;
      rem  = 14'(t_r - 16'(QUARTER_TURN));
    end else begin
      quad = 2'd0;
      rem  = t_r[13:0];
    end
    swap = rem > 14'(EIGHTH_TURN);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      u1_r      <= swap ? 13'(14'(QUARTER_TURN) - rem) : rem[12:0];
      side_r[1] <= '{quad: quad, swap: swap, x: '0, x2: '0};
    end
  end

  // stage 2: angle in radians, Q30
  assign x_prod = 48'(u1_r) * RAD_K + 48'd32768;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      side_r[2] <= '{quad: side_r[1].quad, swap: side_r[1].swap,
                     x: x_prod[45:16], x2: '0};
    end
  end

  // stage 3: x squared
  assign x2_prod = 60'(side_r[2].x) * 60'(side_r[2].x);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      side_r[3] <= '{quad: side_r[2].quad, swap: side_r[2].swap,
                     x: side_r[2].x, x2: x2_prod[59:30]};
    end
  end

  for (genvar k = 4; k <= TRIG_ST - 2; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k]) side_r[k] <= side_r[k-1];
    end
  end

  // Horner steps: multiply stage, then reciprocal-multiply stage
  assign hc_in[0] = H_ONE;
  assign hs_in[0] = H_ONE;

  for (genvar j = 0; j < 5; j++) begin : g_cos
    localparam int unsigned KC = COS_DIV[j];
    localparam int          SC = 30 + $clog2(KC);
    localparam logic [31:0] MC = 32'(((64'd1 << SC) + 64'(KC) - 64'd1) / 64'(KC));
    logic [60:0] prod;
    logic [29:0] p_r;
    logic [61:0] q_r;
    assign prod = 61'(side_r[3+2*j].x2) * 61'(hc_in[j]);
    always_ff @(posedge clk) begin
      if (en[4+2*j]) p_r <= prod[59:30];
      if (en[5+2*j]) q_r <= 62'(p_r) * 62'(MC);
    end
    assign hc_in[j+1] = H_ONE - 31'(q_r >> SC);
  end

  for (genvar j = 0; j < 4; j++) begin : g_sin
    localparam int unsigned KS = SIN_DIV[j];
    localparam int          SS = 30 + $clog2(KS);
    localparam logic [31:0] MS = 32'(((64'd1 << SS) + 64'(KS) - 64'd1) / 64'(KS));
    logic [60:0] prod;
    logic [29:0] p_r;
    logic [61:0] q_r;
    assign prod = 61'(side_r[3+2*j].x2) * 61'(hs_in[j]);
    always_ff @(posedge clk) begin
      if (en[4+2*j]) p_r <= prod[59:30];
      if (en[5+2*j]) q_r <= 62'(p_r) * 62'(MS);
    end
    assign hs_in[j+1] = H_ONE - 31'(q_r >> SS);
  end

  // sine series is one step shorter; hold it alongside the last cosine step
  always_ff @(posedge clk) begin
    if (en[12]) hsp_r <= hs_in[4];
    if (en[13]) hsq_r <= hsp_r;
  end

  // final stage: sin = x*h, then octant swap and quadrant map
  assign s_prod = 61'(side_r[13].x) * 61'(hsq_r);
  assign c0     = hc_in[5];
  assign s0     = s_prod[60:30];

  always_comb begin
    cv = side_r[13].swap ? $signed({1'b0, s0}) : $signed({1'b0, c0});
    sv = side_r[13].swap ? $signed({1'b0, c0}) : $signed({1'b0, s0});
  end

  always_ff @(posedge clk) begin
    if (en[14]) begin
      case (side_r[13].quad)
        2'd0: begin
          cos_r <= cv;
          sin_r <= sv;
        end
        2'd1: begin
          cos_r <= -sv;
          sin_r <= cv;
        end
        2'd2: begin
          cos_r <= -cv;
          sin_r <= -sv;
        end
        default: begin
          cos_r <= sv;
          sin_r <= -cv;
        end
      endcase
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;
endmodule

// ----- src/afr_cfg.sv -----
// APB register for sigma and a serial divider producing round(2^32/sigma^2).
// Depends on afr_pkg.
`timescale 1ns / 1ps

module afr_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output afr_pkg::cfg_stat_t stat
);
  import afr_pkg::*;

  typedef enum logic [2:0] {
    CFG_IDLE = 3'b001,
    CFG_SQR  = 3'b010,
    CFG_DIV  = 3'b100
  } cfg_state_t;

  cfg_state_t  state_r;
  logic [15:0] sigma_r;
  logic [32:0] inv_r;
  logic [31:0] den_r;
  logic [31:0] rem_r;
  logic [33:0] quo_r;
  logic [5:0]  cnt_r;
  logic        wr;
  logic [15:0] sg;
  logic [31:0] sq;
  logic [32:0] trial;
  logic        ge;
  logic [31:0] rem_nxt;
  logic [33:0] quo_nxt;

  always_comb begin
    wr      = psel & penable & pwrite & (paddr == ADDR_SIGMA);
    sg      = (sigma_r == 16'd0) ? 16'd1 : sigma_r;
    sq      = 32'(sg) * 32'(sg);
    trial   = {rem_r, quo_r[33]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? 32'(trial - {1'b0, den_r}) : trial[31:0];
    quo_nxt = {quo_r[32:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CFG_IDLE;
      sigma_r <= SIGMA_RST;
      inv_r   <= INV_RST;
      cnt_r   <= '0;
    end else if (wr) begin
      sigma_r <= pwdata[15:0];
      state_r <= CFG_SQR;
    end else begin
      unique case (state_r)
        CFG_IDLE: state_r <= CFG_IDLE;
        CFG_SQR: begin
          den_r   <= sq;
          rem_r   <= '0;
          quo_r   <= 34'h1_0000_0000 + 34'(sq >> 1);
          cnt_r   <= '0;
          state_r <= CFG_DIV;
        end
        CFG_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(DIV_STEPS - 1)) begin
            inv_r   <= quo_nxt[32:0];
            state_r <= CFG_IDLE;
          end
        end
        default: state_r <= CFG_IDLE;
      endcase
    end
  end

  assign prdata = (paddr == ADDR_SIGMA) ? {16'd0, sigma_r} : 32'd0;
  assign pready = 1'b1;
  assign stat   = '{busy: (state_r != CFG_IDLE), inv: inv_r};
endmodule

// ----- src/afr_rot.sv -----
// Rotation matrix, rotate-and-subtract residual, scaling and saturation.
// Depends on afr_pkg. Seven stages, one per en bit.
`timescale 1ns / 1ps

module afr_rot (
  input  logic                        clk,
  input  logic [afr_pkg::ROT_ST-1:0]  en,
  input  afr_pkg::q30_t               cos_i,
  input  afr_pkg::q30_t               sin_i,
  input  afr_pkg::side_t              side,
  input  logic [32:0]                 inv,
  output afr_pkg::vec_t               eta_x,
  output afr_pkg::vec_t               eta_y,
  output afr_pkg::vec_t               eta_z,
  output afr_pkg::udata_t             info_diag
);
  import afr_pkg::*;

  q30_t               ce;
  q30_t               se;
  q30_t               ce0_r, se0_r, c0_r, s0_r;
  q30_t               ce1_r, se1_r, c1_r, s1_r;
  logic signed [63:0] pcs_r, pss_r, pcc_r, psc_r;
  q30_t               m01_r, m02_r, m11_r, m12_r;
  vec_t               nb0_r [3];
  vec_t               nb1_r [3];
  vec_t               est_r [4][3];
  q30_t               coef [3][3];
  logic signed [63:0] prod_r [3][3];
  logic signed [33:0] rot_r [3];
  logic signed [34:0] nu_r [3];
  logic               neg_r [3];
  logic [50:0]        hi_r [3];
  logic [49:0]        lo_r [3];
  vec_t               eta_r [3];
  udata_t             info_r;

  always_comb begin
    case (side.edge_index)
      EDGE_120: begin
        ce = Q30_MH;
        se = SIN60;
      end
      EDGE_240: begin
        ce = Q30_MH;
        se = -SIN60;
      end
      default: begin
        ce = Q30_P1;
        se = '0;
      end
    endcase
  end

  // R0: products for the edge-dependent entries
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ce0_r    <= ce;
      se0_r    <= se;
      c0_r     <= cos_i;
      s0_r     <= sin_i;
      pcs_r    <= 64'(cos_i) * 64'(se);
      pss_r    <= 64'(sin_i) * 64'(se);
      pcc_r    <= 64'(cos_i) * 64'(ce);
      psc_r    <= 64'(sin_i) * 64'(ce);
      nb0_r    <= '{side.nb_x, side.nb_y, side.nb_z};
      est_r[0] <= '{side.est_x, side.est_y, side.est_z};
    end
  end

  // R1: round to Q30 entries
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ce1_r    <= ce0_r;
      se1_r    <= se0_r;
      c1_r     <= c0_r;
      s1_r     <= s0_r;
      m01_r    <= -32'(round_q30(pcs_r));
      m02_r    <= 32'(round_q30(pss_r));
      m11_r    <= -32'(round_q30(pcc_r));
      m12_r    <= 32'(round_q30(psc_r));
      nb1_r    <= nb0_r;
      est_r[1] <= est_r[0];
    end
  end

  always_comb begin
    coef[0] = '{-ce1_r, m01_r, m02_r};
    coef[1] = '{se1_r, m11_r, m12_r};
    coef[2] = '{32'sd0, s1_r, c1_r};
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    logic signed [63:0] sum;
    logic signed [34:0] nu_w;
    logic [51:0]        res;

    // R2: matrix row times neighbour vector
    for (genvar k = 0; k < 3; k++) begin : g_col
      always_ff @(posedge clk) begin
        if (en[2]) prod_r[i][k] <= 64'(coef[i][k]) * 64'(nb1_r[k]);
      end
    end

    // R3: exact dot product rounded to Q16
    assign sum = prod_r[i][0] + prod_r[i][1] + prod_r[i][2];

    // R4: residual, R5: scale by 1/sigma^2 in two halves
    assign nu_w = 35'(rot_r[i]) - 35'(est_r[3][i]);

    // R6: recombine and saturate
    assign res = 52'(hi_r[i]) + 52'((51'(lo_r[i]) + 51'd32768) >> 16);

    always_ff @(posedge clk) begin
      if (en[3]) rot_r[i] <= 34'(round_q30(sum));
      if (en[4]) nu_r[i]  <= nu_w;
      if (en[5]) begin
        neg_r[i] <= nu_r[i][34];
        hi_r[i]  <= 51'(nu_r[i][34] ? 34'(-nu_r[i]) : 34'(nu_r[i])) * 51'(inv[32:16]);
        lo_r[i]  <= 50'(nu_r[i][34] ? 34'(-nu_r[i]) : 34'(nu_r[i])) * 50'(inv[15:0]);
      end
      if (en[6]) begin
        if (neg_r[i]) begin
          eta_r[i] <= (res >= 52'h8000_0000) ? 32'sh8000_0000 : -$signed(res[31:0]);
        end else begin
          eta_r[i] <= (res > 52'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(res[31:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) est_r[2] <= est_r[1];
    if (en[3]) est_r[3] <= est_r[2];
    if (en[6]) info_r   <= inv[32] ? 32'hFFFF_FFFF : inv[31:0];
  end

  assign eta_x     = eta_r[0];
  assign eta_y     = eta_r[1];
  assign eta_z     = eta_r[2];
  assign info_diag = info_r;
endmodule

// ----- src/afr_chk.sv -----
// Port-level checker for angle_factor_rotate_residual, bound to the top.
// Depends on afr_pkg and angle_factor_rotate_residual_macros.svh.
`timescale 1ns / 1ps
`include "angle_factor_rotate_residual_macros.svh"

module afr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] eta_x,
  input logic [31:0] eta_y,
  input logic [31:0] eta_z,
  input logic [31:0] info_diag,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [1:0]  paddr
);
  import afr_pkg::*;

  `AFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(eta_x) && $stable(eta_y) && $stable(eta_z) && $stable(info_diag), "stalled result word changed")

  // 1/sigma^2 rounds to at least one for any 16-bit sigma
  `AFR_ASSERT_NOW(a_info_nz, out_valid, info_diag != 32'd0, "info_diag is zero")

  // sigma write starts the divider, which holds off input
  `AFR_ASSERT_NEXT(a_cfg_busy, psel && penable && pwrite && paddr == ADDR_SIGMA, !in_ready, "input taken during divide")

  `AFR_ASSERT_NOW(a_rst_empty, $rose(rst_n), !out_valid, "result word valid right after reset")

endmodule

bind angle_factor_rotate_residual afr_chk u_afr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .eta_x     (out_if.eta_x),
  .eta_y     (out_if.eta_y),
  .eta_z     (out_if.eta_z),
  .info_diag (out_if.info_diag),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr)
);
